>>> hdl/scara_ik_pkg.sv
// ----------------------------------------------------------------------------
// scara_ik_pkg
// Widths, constants, item types and the arctangent table for the two-link
// arm inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package scara_ik_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int CORDIC_STEPS = 24;
  localparam int LEN_W        = 20;
  localparam int ANG_W        = 23;
  localparam int IDX_W        = 2;

  localparam logic [IDX_W-1:0] REG_UPPER_ARM = 2'd0;
  localparam logic [IDX_W-1:0] REG_FOREARM   = 2'd1;
  localparam logic [LEN_W-1:0] LEN_RESET     = 20'd102400;

  localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 1 + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * ANG_W + 7) / 8) * 8;

  // elbow cosine path
  localparam int SQ_W       = 2 * COORD_WIDTH;
  localparam int PROD_W     = 2 * LEN_W;
  localparam int DEN_W      = PROD_W + 1;
  localparam int MAG_W      = (SQ_W > DEN_W) ? SQ_W : DEN_W;
  localparam int DIV_STEPS  = 31;
  localparam int Q_W        = DIV_STEPS + 1;
  localparam int CM_W       = 31;
  localparam int C_W        = CM_W + 1;
  localparam int RAD_W      = 61;
  localparam int SQRT_STEPS = 31;

  // CORDIC
  localparam int CIN_W  = 53;
  localparam int NRM_W  = 30;
  localparam int ZW     = 34;
  localparam int BASE_W = ZW + 2;
  localparam int SHW    = $clog2(CIN_W);

  localparam logic signed [ZW-1:0]     PI_Q30 = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0]  PI_Q20 = 23'sd3294199;
  localparam logic [Q_W-1:0]           ONE_Q30 = Q_W'(1) << 30;
  localparam logic [RAD_W-1:0]         ONE_SQ = RAD_W'(1) << (RAD_W - 1);

  localparam int CORDIC_LAT = CORDIC_STEPS + 4;
  localparam int PRE_STAGES = 4 + DIV_STEPS + 3 + SQRT_STEPS + 3;
  localparam int PIPE_DEPTH = PRE_STAGES + CORDIC_LAT + 2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic                          right;
    logic                          nneg;
    logic                          reach;
  } itm_t;

  // atan(2^-i) in units of 2^-30 rad
  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] one;
    logic signed [ZW-1:0] r;
    one = ZW'(64'sd1073741824);
    case (i)
      0:       r = 34'sd843314857;
      1:       r = 34'sd497837829;
      2:       r = 34'sd263043837;
      3:       r = 34'sd133525159;
      4:       r = 34'sd67021687;
      5:       r = 34'sd33543516;
      6:       r = 34'sd16775851;
      7:       r = 34'sd8388437;
      8:       r = 34'sd4194283;
      9:       r = 34'sd2097149;
      default: r = one >>> i;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/scara_ik_cordic.sv
// ----------------------------------------------------------------------------
// scara_ik_cordic
// Pipelined vectoring CORDIC: atan2(vec_y, vec_x) in units of 2^-30 rad.
// ----------------------------------------------------------------------------
module scara_ik_cordic (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [scara_ik_pkg::CIN_W-1:0]  vec_x,
  input  logic signed [scara_ik_pkg::CIN_W-1:0]  vec_y,
  output logic signed [scara_ik_pkg::ZW-1:0]     angle
);

  localparam int CIN_W = scara_ik_pkg::CIN_W;
  localparam int ZW    = scara_ik_pkg::ZW;
  localparam int SHW   = scara_ik_pkg::SHW;
  localparam int NRM_W = scara_ik_pkg::NRM_W;
  localparam int STEPS = scara_ik_pkg::CORDIC_STEPS;
  localparam logic [SHW-1:0] TOP_POS = SHW'(NRM_W - 1);

  // fold into right half plane
  logic                    xneg;
  logic signed [CIN_W-1:0] fx;
  logic signed [CIN_W-1:0] fy;
  logic                    neg_nxt;
  logic [CIN_W-1:0]        uy_nxt;
  logic signed [ZW-1:0]    off_nxt;

  assign xneg    = vec_x[CIN_W-1];
  assign fx      = xneg ? -vec_x : vec_x;
  assign fy      = xneg ? -vec_y : vec_y;
  assign neg_nxt = fy[CIN_W-1];
  assign uy_nxt  = neg_nxt ? -fy : fy;
  assign off_nxt = !xneg ? '0 : (vec_y[CIN_W-1] ? -scara_ik_pkg::PI_Q30
                                                 : scara_ik_pkg::PI_Q30);

  logic [CIN_W-1:0]     ux0_r, uy0_r;
  logic                 neg0_r, zero0_r;
  logic signed [ZW-1:0] off0_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux0_r   <= fx;
      uy0_r   <= uy_nxt;
      neg0_r  <= neg_nxt;
      zero0_r <= (vec_x == '0) && (vec_y == '0);
      off0_r  <= off_nxt;
    end
  end

  // leading one of the larger magnitude
  logic [CIN_W-1:0] mor;
  logic [SHW-1:0]   pos_nxt;

  assign mor = ux0_r | uy0_r;

  always_comb begin
    pos_nxt = '0;
    for (int b = 0; b < CIN_W; b++) begin
      if (mor[b]) pos_nxt = SHW'(b);
    end
  end

  logic [CIN_W-1:0]     ux1_r, uy1_r;
  logic [SHW-1:0]       pos1_r;
  logic                 neg1_r, zero1_r;
  logic signed [ZW-1:0] off1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ux1_r   <= ux0_r;
      uy1_r   <= uy0_r;
      pos1_r  <= pos_nxt;
      neg1_r  <= neg0_r;
      zero1_r <= zero0_r;
      off1_r  <= off0_r;
    end
  end

  // scale so the larger coordinate lands in [2^29, 2^30)
  logic [CIN_W-1:0] nx, ny;

  always_comb begin
    if (pos1_r > TOP_POS) begin
      nx = ux1_r >> (pos1_r - TOP_POS);
      ny = uy1_r >> (pos1_r - TOP_POS);
    end else begin
      nx = ux1_r << (TOP_POS - pos1_r);
      ny = uy1_r << (TOP_POS - pos1_r);
    end
  end

  logic signed [ZW-1:0] bx_r  [0:STEPS];
  logic signed [ZW-1:0] by_r  [0:STEPS];
  logic signed [ZW-1:0] z_r   [0:STEPS];
  logic signed [ZW-1:0] off_r [0:STEPS];
  logic                 neg_r [0:STEPS];
  logic                 zero_r[0:STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      bx_r[0]   <= $signed({{(ZW-NRM_W){1'b0}}, nx[NRM_W-1:0]});
      by_r[0]   <= $signed({{(ZW-NRM_W){1'b0}}, ny[NRM_W-1:0]});
      z_r[0]    <= '0;
      off_r[0]  <= off1_r;
      neg_r[0]  <= neg1_r;
      zero_r[0] <= zero1_r;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATN = scara_ik_pkg::atan_step(i);
    logic signed [ZW-1:0] dx, dy;
    assign dx = by_r[i] >>> i;
    assign dy = bx_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!by_r[i][ZW-1]) begin
          bx_r[i+1] <= bx_r[i] + dx;
          by_r[i+1] <= by_r[i] - dy;
          z_r[i+1]  <= z_r[i] + ATN;
        end else begin
          bx_r[i+1] <= bx_r[i] - dx;
          by_r[i+1] <= by_r[i] + dy;
          z_r[i+1]  <= z_r[i] - ATN;
        end
        off_r[i+1]  <= off_r[i];
        neg_r[i+1]  <= neg_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  logic signed [ZW-1:0] zz;
  logic signed [ZW-1:0] angle_r;

  assign zz = neg_r[STEPS] ? -z_r[STEPS] : z_r[STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zero_r[STEPS] ? '0 : zz + off_r[STEPS];
    end
  end

  assign angle = angle_r;

endmodule

>>> hdl/scara_two_link_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// scara_two_link_inverse_kinematics
// Shoulder and elbow angles of a two-link planar arm for a target point.
// ----------------------------------------------------------------------------
// One target point per clock while the output is not stalled. The pipeline
// is the 31-stage restoring divider for the elbow cosine, the 31-stage
// square root for the sine and the three parallel CORDIC pipelines
// (steps + 4), plus twelve register stages for the squares, reach check,
// rounding, CORDIC operands, base wrap and output.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// The user must write link lengths through the cfg port only while no item
// is in flight; the block does not enforce it.
module scara_two_link_inverse_kinematics (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // in_tdata: target_x, target_y, right_handed (from bit 0 up), zero padded
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [scara_ik_pkg::IN_TDATA_W-1:0]       in_tdata,
  // out_tdata: base_angle, elbow_angle (from bit 0 up), zero padded
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [scara_ik_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // out_tuser: reachable
  output logic                                      out_tuser,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [scara_ik_pkg::IDX_W-1:0]            cfg_index,
  input  logic [scara_ik_pkg::LEN_W-1:0]            cfg_data
);

  localparam int CW       = scara_ik_pkg::COORD_WIDTH;
  localparam int LEN_W    = scara_ik_pkg::LEN_W;
  localparam int ANG_W    = scara_ik_pkg::ANG_W;
  localparam int SQ_W     = scara_ik_pkg::SQ_W;
  localparam int PROD_W   = scara_ik_pkg::PROD_W;
  localparam int DEN_W    = scara_ik_pkg::DEN_W;
  localparam int MAG_W    = scara_ik_pkg::MAG_W;
  localparam int DSTEPS   = scara_ik_pkg::DIV_STEPS;
  localparam int Q_W      = scara_ik_pkg::Q_W;
  localparam int CM_W     = scara_ik_pkg::CM_W;
  localparam int C_W      = scara_ik_pkg::C_W;
  localparam int RAD_W    = scara_ik_pkg::RAD_W;
  localparam int RSTEPS   = scara_ik_pkg::SQRT_STEPS;
  localparam int CIN_W    = scara_ik_pkg::CIN_W;
  localparam int ZW       = scara_ik_pkg::ZW;
  localparam int BASE_W   = scara_ik_pkg::BASE_W;
  localparam int CLAT     = scara_ik_pkg::CORDIC_LAT;
  localparam int DEPTH    = scara_ik_pkg::PIPE_DEPTH;
  localparam int SQ_STG   = 4 + DSTEPS + 3 + RSTEPS - 1;
  localparam int OUT_PAD  = scara_ik_pkg::OUT_TDATA_W - 2 * ANG_W;

  localparam logic signed [BASE_W-1:0] PI_B   = BASE_W'(scara_ik_pkg::PI_Q30);
  localparam logic signed [BASE_W-1:0] TWO_PI = PI_B + PI_B;
  localparam logic signed [BASE_W-1:0] HALF   = BASE_W'(64'sd512);
  localparam logic signed [BASE_W-1:0] LIM20  = BASE_W'(scara_ik_pkg::PI_Q20);

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  logic             en;
  logic [DEPTH-1:0] vld_r;

  assign out_tvalid = vld_r[DEPTH-1];
  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // link lengths and derived constants
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  l1_r, l2_r;
  logic [PROD_W-1:0] l1sq_r, l2sq_r, l12_r;
  logic [DEN_W-1:0]  lsq_r, den_r;
  logic [PROD_W-1:0] l1sq_nxt, l2sq_nxt, l12_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r <= scara_ik_pkg::LEN_RESET;
      l2_r <= scara_ik_pkg::LEN_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        scara_ik_pkg::REG_UPPER_ARM: l1_r <= cfg_data;
        scara_ik_pkg::REG_FOREARM:   l2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign l1sq_nxt = PROD_W'(l1_r) * PROD_W'(l1_r);
  assign l2sq_nxt = PROD_W'(l2_r) * PROD_W'(l2_r);
  assign l12_nxt  = PROD_W'(l1_r) * PROD_W'(l2_r);

  always_ff @(posedge clk) begin
    l1sq_r <= l1sq_nxt;
    l2sq_r <= l2sq_nxt;
    l12_r  <= l12_nxt;
    lsq_r  <= DEN_W'(l1sq_r) + DEN_W'(l2sq_r);
    den_r  <= {l12_r, 1'b0};
  end

  // --------------------------------------------------------------------------
  // stages 1-4: magnitudes, squares, numerator, reach check, first quotient bit
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] in_x, in_y;
  logic [CW-1:0]        ax_nxt, ay_nxt;

  assign in_x   = in_tdata[CW-1:0];
  assign in_y   = in_tdata[2*CW-1:CW];
  assign ax_nxt = in_x[CW-1] ? -in_x : in_x;
  assign ay_nxt = in_y[CW-1] ? -in_y : in_y;

  scara_ik_pkg::itm_t it1_r, it2_r, it3_r;
  logic [CW-1:0]      ax1_r, ay1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r.x     <= in_x;
      it1_r.y     <= in_y;
      it1_r.right <= in_tdata[2*CW];
      it1_r.nneg  <= 1'b0;
      it1_r.reach <= 1'b0;
      ax1_r       <= ax_nxt;
      ay1_r       <= ay_nxt;
    end
  end

  logic [SQ_W-1:0] sqx_nxt, sqy_nxt, sqx2_r, sqy2_r;

  assign sqx_nxt = SQ_W'(ax1_r) * SQ_W'(ax1_r);
  assign sqy_nxt = SQ_W'(ay1_r) * SQ_W'(ay1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      it2_r  <= it1_r;
      sqx2_r <= sqx_nxt;
      sqy2_r <= sqy_nxt;
    end
  end

  logic [MAG_W-1:0] sq3, lsq3;
  logic             nneg_nxt;
  logic [MAG_W-1:0] mag3_r;

  assign sq3      = MAG_W'(sqx2_r + sqy2_r);
  assign lsq3     = MAG_W'(lsq_r);
  assign nneg_nxt = sq3 < lsq3;

  always_ff @(posedge clk) begin
    if (en) begin
      it3_r  <= '{x: it2_r.x, y: it2_r.y, right: it2_r.right, nneg: nneg_nxt,
                  reach: it2_r.reach};
      mag3_r <= nneg_nxt ? lsq3 - sq3 : sq3 - lsq3;
    end
  end

  // reachable when den is nonzero and |num| <= den + den/2^28 (radicand above about -1e-8)
  logic [MAG_W:0]   lim4;
  logic             reach_nxt;
  logic             ge4;
  logic [MAG_W-1:0] rem4;

  assign lim4      = (MAG_W+1)'(den_r) + (MAG_W+1)'(den_r >> 28);
  assign reach_nxt = (den_r != '0) && ((MAG_W+1)'(mag3_r) <= lim4);
  assign ge4       = mag3_r >= MAG_W'(den_r);
  assign rem4      = ge4 ? mag3_r - MAG_W'(den_r) : mag3_r;

  scara_ik_pkg::itm_t dit_r[0:DSTEPS];
  logic [DEN_W-1:0]   dr_r [0:DSTEPS];
  logic [Q_W-1:0]     dq_r [0:DSTEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dit_r[0] <= '{x: it3_r.x, y: it3_r.y, right: it3_r.right, nneg: it3_r.nneg,
                    reach: reach_nxt};
      dr_r[0]  <= rem4[DEN_W-1:0];
      dq_r[0]  <= Q_W'(ge4);
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider, one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= DSTEPS; k++) begin : g_div
    logic [DEN_W:0] sh, dif;
    logic           ge;
    assign sh  = {dr_r[k-1], 1'b0};
    assign ge  = sh >= {1'b0, den_r};
    assign dif = sh - {1'b0, den_r};
    always_ff @(posedge clk) begin
      if (en) begin
        dit_r[k] <= dit_r[k-1];
        dr_r[k]  <= ge ? dif[DEN_W-1:0] : sh[DEN_W-1:0];
        dq_r[k]  <= {dq_r[k-1][Q_W-2:0], ge};
      end
    end
  end

  // --------------------------------------------------------------------------
  // cosine rounding, c^2, radicand
  // --------------------------------------------------------------------------
  logic [Q_W:0]   qp;
  logic [Q_W-1:0] qh;
  logic [CM_W-1:0] cm_nxt;
  logic signed [C_W-1:0] c_nxt;

  assign qp     = (Q_W+1)'(dq_r[DSTEPS]) + (Q_W+1)'(1);
  assign qh     = qp[Q_W:1];
  assign cm_nxt = (qh > scara_ik_pkg::ONE_Q30) ? scara_ik_pkg::ONE_Q30[CM_W-1:0]
                                                : qh[CM_W-1:0];
  assign c_nxt  = dit_r[DSTEPS].nneg ? -$signed({1'b0, cm_nxt})
                                     : $signed({1'b0, cm_nxt});

  scara_ik_pkg::itm_t    it36_r, it37_r;
  logic [CM_W-1:0]       cm36_r;
  logic signed [C_W-1:0] c36_r, c37_r;
  logic [RAD_W-1:0]      csq_nxt, csq37_r;

  always_ff @(posedge clk) begin
    if (en) begin
      it36_r <= dit_r[DSTEPS];
      cm36_r <= cm_nxt;
      c36_r  <= c_nxt;
    end
  end

  assign csq_nxt = RAD_W'(cm36_r) * RAD_W'(cm36_r);

  always_ff @(posedge clk) begin
    if (en) begin
      it37_r  <= it36_r;
      c37_r   <= c36_r;
      csq37_r <= csq_nxt;
    end
  end

  scara_ik_pkg::itm_t    sit_r [0:RSTEPS];
  logic signed [C_W-1:0] sc_r  [0:RSTEPS];
  logic [RAD_W-1:0]      sv_r  [0:RSTEPS];
  logic [RAD_W-1:0]      sres_r[0:RSTEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sit_r[0]  <= it37_r;
      sc_r[0]   <= c37_r;
      sv_r[0]   <= scara_ik_pkg::ONE_SQ - csq37_r;
      sres_r[0] <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // integer square root, one result bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= RSTEPS; k++) begin : g_sqrt
    localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (RAD_W - 1 - 2 * (k - 1));
    logic [RAD_W:0] sum;
    logic           ge;
    assign sum = {1'b0, sres_r[k-1]} + BIT;
    assign ge  = {1'b0, sv_r[k-1]} >= sum;
    always_ff @(posedge clk) begin
      if (en) begin
        sit_r[k]  <= sit_r[k-1];
        sc_r[k]   <= sc_r[k-1];
        sv_r[k]   <= ge ? sv_r[k-1] - sum[RAD_W-1:0] : sv_r[k-1];
        sres_r[k] <= ge ? (sres_r[k-1] >> 1) + BIT[RAD_W-1:0] : sres_r[k-1] >> 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // sine sign, forearm projections, CORDIC operands
  // --------------------------------------------------------------------------
  logic [CM_W-1:0] sroot;
  assign sroot = sres_r[RSTEPS][CM_W-1:0];

  scara_ik_pkg::itm_t    it70_r, it71_r, it72_r;
  logic signed [C_W-1:0] s70_r, c70_r, s71_r, c71_r, s72_r, c72_r;

  always_ff @(posedge clk) begin
    if (en) begin
      it70_r <= sit_r[RSTEPS];
      c70_r  <= sc_r[RSTEPS];
      s70_r  <= sit_r[RSTEPS].right ? $signed({1'b0, sroot}) : -$signed({1'b0, sroot});
    end
  end

  logic signed [CIN_W-1:0] l2s_nxt, l2c_nxt, l2s71_r, l2c71_r;
  logic signed [CIN_W-1:0] a2x72_r, a2y72_r;

  assign l2s_nxt = CIN_W'($signed({1'b0, l2_r})) * CIN_W'(s70_r);
  assign l2c_nxt = CIN_W'($signed({1'b0, l2_r})) * CIN_W'(c70_r);

  always_ff @(posedge clk) begin
    if (en) begin
      it71_r  <= it70_r;
      s71_r   <= s70_r;
      c71_r   <= c70_r;
      l2s71_r <= l2s_nxt;
      l2c71_r <= l2c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it72_r  <= it71_r;
      s72_r   <= s71_r;
      c72_r   <= c71_r;
      a2y72_r <= l2s71_r;
      a2x72_r <= $signed({{(CIN_W-LEN_W-30){1'b0}}, l1_r, 30'b0}) + l2c71_r;
    end
  end

  logic signed [CIN_W-1:0] ex_s, ex_c, ex_x, ex_y;

  assign ex_s = {{(CIN_W-C_W){s72_r[C_W-1]}}, s72_r};
  assign ex_c = {{(CIN_W-C_W){c72_r[C_W-1]}}, c72_r};
  assign ex_x = {{(CIN_W-CW){it72_r.x[CW-1]}}, it72_r.x};
  assign ex_y = {{(CIN_W-CW){it72_r.y[CW-1]}}, it72_r.y};

  logic signed [ZW-1:0] elb_ang, a1_ang, a2_ang;

  scara_ik_cordic u_cordic_elbow (
    .clk   (clk),
    .en    (en),
    .vec_x (ex_c),
    .vec_y (ex_s),
    .angle (elb_ang)
  );

  scara_ik_cordic u_cordic_target (
    .clk   (clk),
    .en    (en),
    .vec_x (ex_x),
    .vec_y (ex_y),
    .angle (a1_ang)
  );

  scara_ik_cordic u_cordic_forearm (
    .clk   (clk),
    .en    (en),
    .vec_x (a2x72_r),
    .vec_y (a2y72_r),
    .angle (a2_ang)
  );

  logic rdl_r[0:CLAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      rdl_r[0] <= it72_r.reach;
    end
  end

  for (genvar k = 1; k < CLAT; k++) begin : g_rdl
    always_ff @(posedge clk) begin
      if (en) begin
        rdl_r[k] <= rdl_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // base angle wrap, rounding to 2^-20 rad
  // --------------------------------------------------------------------------
  logic signed [BASE_W-1:0] dif_nxt, base_nxt;

  assign dif_nxt = BASE_W'(a1_ang) - BASE_W'(a2_ang);

  always_comb begin
    if (dif_nxt <= -PI_B) begin
      base_nxt = dif_nxt + TWO_PI;
    end else if (dif_nxt > PI_B) begin
      base_nxt = dif_nxt - TWO_PI;
    end else begin
      base_nxt = dif_nxt;
    end
  end

  logic signed [BASE_W-1:0] base_r;
  logic signed [ZW-1:0]     elb_r;
  logic                     rch_r;

  always_ff @(posedge clk) begin
    if (en) begin
      base_r <= base_nxt;
      elb_r  <= elb_ang;
      rch_r  <= rdl_r[CLAT-1];
    end
  end

  function automatic logic signed [ANG_W-1:0] to_q20(input logic signed [BASE_W-1:0] v);
    logic signed [BASE_W-1:0] t;
    t = (v + HALF) >>> 10;
    if (t > LIM20) t = LIM20;
    if (t < -LIM20) t = -LIM20;
    return t[ANG_W-1:0];
  endfunction

  logic signed [BASE_W-1:0] elb_ext;
  logic signed [ANG_W-1:0]  out_base_r, out_elb_r;
  logic                     out_rch_r;

  assign elb_ext = {{(BASE_W-ZW){elb_r[ZW-1]}}, elb_r};

  always_ff @(posedge clk) begin
    if (en) begin
      out_base_r <= rch_r ? to_q20(base_r) : '0;
      out_elb_r  <= rch_r ? to_q20(elb_ext) : '0;
      out_rch_r  <= rch_r;
    end
  end

  assign out_tdata = {{OUT_PAD{1'b0}}, out_elb_r, out_base_r};
  assign out_tuser = out_rch_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("unreachable result carries nonzero angles");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_base_r <= scara_ik_pkg::PI_Q20 &&
                   out_base_r >= -scara_ik_pkg::PI_Q20 &&
                   out_elb_r <= scara_ik_pkg::PI_Q20 &&
                   out_elb_r >= -scara_ik_pkg::PI_Q20)
    else $error("output angle out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] && dit_r[0].reach |-> dr_r[0] < den_r)
    else $error("divider start remainder not below divisor");

  a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[SQ_STG] |-> sres_r[RSTEPS] <= RAD_W'(scara_ik_pkg::ONE_Q30))
    else $error("elbow sine above one");

endmodule

>>> tb/tb_scara_two_link_inverse_kinematics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scara_two_link_inverse_kinematics
// Self-checking bench for the two-link arm inverse kinematics pipeline.
// ----------------------------------------------------------------------------
// A bit-exact joint-angle predictor runs beside the block. Target points are
// queued by the stimulus process, sent by a clocked driver with random gaps,
// and every result is checked against the oldest predicted angle set. Link
// lengths are changed between phases while the pipeline is empty.
module tb_scara_two_link_inverse_kinematics;

  localparam int     CW    = scara_ik_pkg::COORD_WIDTH;
  localparam int     ANG_W = scara_ik_pkg::ANG_W;
  localparam int     LEN_W = scara_ik_pkg::LEN_W;
  localparam int     IDX_W = scara_ik_pkg::IDX_W;
  localparam longint PI_30 = 64'sd3373259426;
  localparam longint PI_20 = 64'sd3294199;
  localparam int     TAIL  = scara_ik_pkg::PIPE_DEPTH + 10;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 right;
  } target_t;

  typedef struct {
    logic signed [ANG_W-1:0] base;
    logic signed [ANG_W-1:0] elbow;
    logic                    reach;
  } joints_t;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   in_tvalid;
  logic                                   in_tready;
  logic [scara_ik_pkg::IN_TDATA_W-1:0]    in_tdata;
  logic                                   out_tvalid;
  logic                                   out_tready;
  logic [scara_ik_pkg::OUT_TDATA_W-1:0]   out_tdata;
  logic                                   out_tuser;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [IDX_W-1:0]                       cfg_index;
  logic [LEN_W-1:0]                       cfg_data;

  target_t    pending_targets[$];
  joints_t    expected_joints[$];
  bit [63:0]  len_upper = 64'(scara_ik_pkg::LEN_RESET);
  bit [63:0]  len_fore  = 64'(scara_ik_pkg::LEN_RESET);
  int         in_idle;
  int         out_idle;
  int         errors;
  logic       in_fire;

  scara_two_link_inverse_kinematics uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end

  // ---- predictor -----------------------------------------------------------
  function automatic longint step_angle(int i);
    case (i)
      0: return 843314857;
      1: return 497837829;
      2: return 263043837;
      3: return 133525159;
      4: return 67021687;
      5: return 33543516;
      6: return 16775851;
      7: return 8388437;
      8: return 4194283;
      9: return 2097149;
      default: return longint'(64'sd1073741824 >>> i);
    endcase
  endfunction

  // vectoring CORDIC, result in 2^-30 rad
  function automatic longint vector_angle(longint y, longint x);
    longint    off = 0;
    longint    z = 0;
    longint    bx, by, dx, dy;
    bit [63:0] ux, uy, m;
    bit        neg;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      off = (y >= 0) ? PI_30 : -PI_30;
      x = -x;
      y = -y;
    end
    neg = (y < 0);
    ux = x;
    if (neg) uy = -y;
    else uy = y;
    m = (ux > uy) ? ux : uy;
    while (m >= (64'd1 << 30)) begin
      ux >>= 1; uy >>= 1; m >>= 1;
    end
    while (m < (64'd1 << 29)) begin
      ux <<= 1; uy <<= 1; m <<= 1;
    end
    bx = ux;
    by = uy;
    for (int i = 0; i < scara_ik_pkg::CORDIC_STEPS; i++) begin
      dx = by >>> i;
      dy = bx >>> i;
      if (by >= 0) begin
        bx += dx; by -= dy; z += step_angle(i);
      end else begin
        bx -= dx; by += dy; z -= step_angle(i);
      end
    end
    return (neg ? -z : z) + off;
  endfunction

  function automatic bit [63:0] root_floor(bit [63:0] v);
    bit [63:0] res = 0;
    bit [63:0] b = 64'd1 << 60;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [ANG_W-1:0] round_q20(longint v);
    longint r = (v + 512) >>> 10;
    if (r > PI_20) r = PI_20;
    if (r < -PI_20) r = -PI_20;
    return r[ANG_W-1:0];
  endfunction

  function automatic joints_t solve_joints(target_t t);
    joints_t   j;
    longint    x = longint'(t.x);
    longint    y = longint'(t.y);
    bit [63:0] ax, ay, sq, lsq, den, mag, r;
    bit [63:0] q = 0;
    bit        nneg;
    longint    c, s, elbow, base;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    sq = ax * ax + ay * ay;
    lsq = len_upper * len_upper + len_fore * len_fore;
    den = 2 * len_upper * len_fore;
    nneg = sq < lsq;
    mag = nneg ? lsq - sq : sq - lsq;
    j = '{base: '0, elbow: '0, reach: 1'b0};
    if (den == 0 || mag > den + (den >> 28)) return j;
    r = mag;
    if (r >= den) begin
      q = 1; r -= den;
    end
    for (int k = 0; k < 31; k++) begin
      r <<= 1; q <<= 1;
      if (r >= den) begin
        r -= den; q |= 1;
      end
    end
    q = (q + 1) >> 1;
    if (q > (64'd1 << 30)) q = 64'd1 << 30;
    c = nneg ? -longint'(q) : longint'(q);
    s = longint'(root_floor((64'd1 << 60) - 64'(c * c)));
    if (!t.right) s = -s;
    elbow = vector_angle(s, c);
    base = vector_angle(y, x) -
           vector_angle(longint'(len_fore) * s,
                        longint'(len_upper) * (64'sd1 << 30) + longint'(len_fore) * c);
    if (base <= -PI_30) base += 2 * PI_30;
    else if (base > PI_30) base -= 2 * PI_30;
    j.base = round_q20(base);
    j.elbow = round_q20(elbow);
    j.reach = 1'b1;
    return j;
  endfunction

  // ---- driver and monitor --------------------------------------------------
  always @(posedge clk) begin
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_joints.push_back(solve_joints('{x: in_tdata[23:0], y: in_tdata[47:24],
                                               right: in_tdata[48]}));
  end

  always @(negedge clk) begin
    target_t t;
    if (rst_n) begin
      out_tready <= ($urandom_range(99) >= out_idle);
      if (!in_tvalid || in_fire) begin
        if (pending_targets.size() > 0 && $urandom_range(99) >= in_idle) begin
          t = pending_targets.pop_front();
          in_tdata <= {7'b0, t.right, t.y, t.x};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    joints_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_joints.size() == 0) begin
        report_mismatch("unexpected transfer", 1, 0);
      end else begin
        e = expected_joints.pop_front();
        if (out_tuser !== e.reach) report_mismatch("reachable", out_tuser, e.reach);
        if ($signed(out_tdata[22:0]) !== e.base)
          report_mismatch("base_angle", $signed(out_tdata[22:0]), e.base);
        if ($signed(out_tdata[45:23]) !== e.elbow)
          report_mismatch("elbow_angle", $signed(out_tdata[45:23]), e.elbow);
      end
    end
  end

  // ---- stimulus ------------------------------------------------------------
  task automatic write_length(logic [IDX_W-1:0] idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == scara_ik_pkg::REG_UPPER_ARM) len_upper = val;
    else len_fore = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_empty();
    do @(posedge clk);
    while (pending_targets.size() > 0 || in_tvalid || expected_joints.size() > 0);
  endtask

  task automatic add_target(longint x, longint y, bit right);
    pending_targets.push_back('{x: x[23:0], y: y[23:0], right: right});
  endtask

  task automatic add_corner_cases();
    longint reach_max = len_upper + len_fore;
    longint reach_min = (len_upper > len_fore) ? len_upper - len_fore : len_fore - len_upper;
    if (reach_max > 8388607) reach_max = 8388607;
    add_target(0, 0, 1);
    add_target(0, 0, 0);
    add_target(reach_max, 0, 1);
    add_target(reach_max, 0, 0);
    add_target(0, reach_max, 1);
    add_target(-reach_max, 0, 0);
    add_target(0, -reach_max, 1);
    add_target(reach_max + 1, 0, 1);
    add_target(-reach_max - 1, 0, 0);
    add_target(reach_min, 0, 1);
    add_target(0, -reach_min, 0);
    add_target(len_upper, len_fore, 1);
    add_target(-len_upper, len_fore, 0);
    add_target(-len_upper, -len_fore, 1);
    add_target(-8388608, -8388608, 1);
    add_target(8388607, 8388607, 0);
    add_target(-8388608, 8388607, 1);
    add_target(8388607, -8388608, 0);
    add_target(-1, 0, 1);
    add_target(-1, -1, 0);
  endtask

  task automatic add_random_target();
    longint span = len_upper + len_fore;
    longint x, y;
    int     pick = $urandom_range(99);
    span = span + span / 8 + 2;
    if (span > 8388607) span = 8388607;
    if (pick < 75) begin
      x = longint'($urandom_range(2 * span)) - span;
      y = longint'($urandom_range(2 * span)) - span;
    end else if (pick < 88) begin
      // hug the outer reach circle along an axis
      x = len_upper + len_fore + longint'($urandom_range(8)) - 4;
      y = longint'($urandom_range(2)) - 1;
      if ($urandom_range(1)) x = -x;
      if (x > 8388607) x = 8388607;
      if (x < -8388608) x = -8388608;
      if ($urandom_range(1)) begin
        y = x; x = 0;
      end
    end else begin
      x = $signed(24'($urandom));
      y = $signed(24'($urandom));
    end
    add_target(x, y, $urandom_range(1));
  endtask

  initial begin
    int uppers[6] = '{102400, 1048575, 1, 50000, 0, 300000};
    int fores[6]  = '{102400, 1048575, 1, 150000, 0, 7000};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = scara_ik_pkg::REG_UPPER_ARM;
    cfg_data = '0;
    errors = 0;
    in_idle = 29;
    out_idle = 79;
    uppers[4] = $urandom_range(1048575, 1);
    fores[4] = $urandom_range(1048575, 1);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        in_idle = 79; out_idle = 29;
      end else if (ph == 4) begin
        in_idle = 0; out_idle = 0;
      end
      if (ph > 0) begin
        write_length(scara_ik_pkg::REG_UPPER_ARM, uppers[ph][LEN_W-1:0]);
        write_length(scara_ik_pkg::REG_FOREARM, fores[ph][LEN_W-1:0]);
      end
      if (ph == 0 || ph == 1 || ph == 2) add_corner_cases();
      for (int n = 0; n < 300; n++) begin
        add_random_target();
        // let the pipeline run dry once mid-stream
        if (ph == 0 && n == 150) wait_empty();
      end
      wait_empty();
      repeat (TAIL) @(posedge clk);
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
